// ----- sv/gbk_pkg.sv -----
// Shared types, constants and sizes for the GBK glyph cache slot allocator.
package gbk_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 17;
    localparam int OFFSET_W  = 22;
    localparam int FS_W      = 6;
    localparam int CS_W      = 9;
    localparam int FACTOR_W  = 8;
    localparam int SLOTF_W   = 8;
    localparam int CTRL_W    = 5;
    localparam int USED_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_SLOTS = 1'd1;

    localparam logic [FS_W-1:0] FS_RESET = 6'd16;
    localparam logic [FS_W-1:0] FS_MIN   = 6'd8;
    localparam logic [FS_W-1:0] FS_MAX   = 6'd32;
    localparam logic [FS_W-1:0] FS_WIDE  = 6'd16;
    localparam logic [CS_W-1:0] CS_RESET = 9'd256;

    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [BYTE_W-1:0] SB_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_BASE  = 8'h81;
    localparam logic [BYTE_W-1:0] TRAIL_BASE = 8'h40;
    localparam logic [CODE_W-1:0] ROW_SPAN   = 17'd191;
    localparam logic [CODE_W-1:0] SB_FLAG    = 17'h10000;

    localparam logic [USED_W-1:0] USED_ONE = 2'd1;
    localparam logic [USED_W-1:0] USED_TWO = 2'd2;

    typedef enum logic [1:0] {
        KIND_SINGLE  = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_CONTROL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_ALLOC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic search_start;
        logic search_step;
        logic alloc;
        logic out_load;
    } gbk_cmd_t;

    typedef struct packed {
        logic is_glyph;
        logic hit;
        logic miss;
        logic out_free;
    } gbk_stat_t;

endpackage

// ----- sv/gbk_if.sv -----
// Valid/ready channel interfaces for characters in and allocation results out.
interface gbk_char_if import gbk_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] trail_byte;

    modport source (output valid, output lead_byte, output trail_byte, input ready);
    modport sink   (input valid, input lead_byte, input trail_byte, output ready);
endinterface

interface gbk_res_if import gbk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [SLOTF_W-1:0]  slot;
    logic                hit;
    logic [CODE_W-1:0]   glyph_code;
    logic [OFFSET_W-1:0] font_offset;
    logic [CTRL_W-1:0]   control_char;
    logic [USED_W-1:0]   bytes_used;
    logic                bad_trail;

    modport source (output valid, output kind, output slot, output hit, output glyph_code,
                    output font_offset, output control_char, output bytes_used,
                    output bad_trail, input ready);
    modport sink   (input valid, input kind, input slot, input hit, input glyph_code,
                    input font_offset, input control_char, input bytes_used,
                    input bad_trail, output ready);
endinterface

// ----- sv/gbk_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module gbk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/gbk_ctrl.sv -----
// Sequencer for decode, slot search, allocation and result hand-off.
module gbk_ctrl import gbk_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gbk_stat_t st,
    output gbk_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.search_start = 1'b1;
                state_next       = st.is_glyph ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (st.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (st.miss)
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/gbk_datapath.sv -----
// Glyph decode, offset multiply, slot table search and FIFO fill pointer.
module gbk_datapath import gbk_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbk_cmd_t             cmd,
    output gbk_stat_t            st,
    input  logic [BYTE_W-1:0]    lead_byte,
    input  logic [BYTE_W-1:0]    trail_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    gbk_res_if.source            res
);

    logic [FS_W-1:0]     fs_reg;
    logic [CS_W-1:0]     cs_reg;
    logic [BYTE_W-1:0]   lead_reg;
    logic [BYTE_W-1:0]   trail_reg;
    kind_t               kind_reg;
    logic                bad_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CODE_W-1:0]   base_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                cmp_valid_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic                cmp_vbit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   fill_ptr_reg;
    logic [SLOT_W-1:0]   fill_ptr_next;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic                res_valid_reg;

    logic [CODE_W-1:0]   rd_data;
    logic                is_ctrl;
    logic                is_dbl;
    logic                is_bad;
    kind_t               kind_next;
    logic [CODE_W-1:0]   code_next;
    logic [CODE_W-1:0]   base_next;
    logic [FACTOR_W-1:0] factor_next;
    logic [FS_W-1:0]     fs_eff;
    logic [6:0]          fs_sum;
    logic [CNT_W-1:0]    n_act;
    logic [CNT_W-1:0]    n_last;
    logic [SLOT_W-1:0]   fp_eff;
    logic [CNT_W-1:0]    fp_inc;
    logic                issue;
    logic                match;
    logic [CODE_W+FACTOR_W-1:0] product;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
            cs_reg <= CS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FONT_SIZE:   fs_reg <= cfg_data[FS_W-1:0];
                REG_CACHE_SLOTS: cs_reg <= cfg_data[CS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (cs_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(cs_reg) > MAX_SLOTS)
        begin
            n_act = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_act = CNT_W'(cs_reg);
        end
        n_last = n_act - CNT_W'(1);
    end

    // Character decode from the captured bytes.
    always_comb
    begin
        is_ctrl = lead_reg < CTRL_LIMIT;
        is_dbl  = lead_reg > SB_LIMIT;
        is_bad  = is_dbl && (trail_reg < TRAIL_BASE);

        if (fs_reg < FS_MIN)
        begin
            fs_eff = FS_MIN;
        end
        else if (fs_reg > FS_MAX)
        begin
            fs_eff = FS_MAX;
        end
        else
        begin
            fs_eff = fs_reg;
        end
        fs_sum = {1'b0, fs_eff} + 7'd7;

        if (is_ctrl)
        begin
            kind_next   = KIND_CONTROL;
            code_next   = '0;
            base_next   = '0;
            factor_next = '0;
        end
        else if (is_dbl)
        begin
            kind_next   = KIND_DOUBLE;
            code_next   = is_bad ? '0 :
                          CODE_W'(lead_reg - LEAD_BASE) * ROW_SPAN
                          + CODE_W'(trail_reg - TRAIL_BASE);
            base_next   = code_next;
            factor_next = FACTOR_W'(fs_sum[5:3]) * FACTOR_W'(fs_eff);
        end
        else
        begin
            kind_next   = KIND_SINGLE;
            code_next   = SB_FLAG | CODE_W'(lead_reg);
            base_next   = CODE_W'(lead_reg);
            factor_next = (fs_eff <= FS_WIDE) ? FACTOR_W'(fs_eff) : FACTOR_W'({fs_eff, 1'b0});
        end
    end

    // Search and allocation.
    assign issue = cmd.search_step && (rd_idx_reg < n_act);
    assign match = cmp_valid_reg && cmp_vbit_reg && (rd_data == code_reg);

    always_comb
    begin
        fp_eff        = (CNT_W'(fill_ptr_reg) >= n_act) ? '0 : fill_ptr_reg;
        fp_inc        = CNT_W'(fp_eff) + CNT_W'(1);
        fill_ptr_next = (fp_inc >= n_act) ? '0 : SLOT_W'(fp_inc);
    end

    gbk_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_SLOTS)
    ) u_codes (
        .clk   (clk),
        .we    (cmd.alloc),
        .waddr (fp_eff),
        .wdata (code_reg),
        .raddr (SLOT_W'(rd_idx_reg)),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fill_ptr_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                valid_reg[fp_eff] <= 1'b1;
                fill_ptr_reg      <= fill_ptr_next;
            end
            if (cmd.search_start)
            begin
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.search_step)
            begin
                cmp_valid_reg <= issue;
            end
            if (cmd.out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lead_reg  <= lead_byte;
            trail_reg <= trail_byte;
        end
        if (cmd.search_start)
        begin
            kind_reg   <= kind_next;
            bad_reg    <= is_bad;
            code_reg   <= code_next;
            base_reg   <= base_next;
            factor_reg <= factor_next;
            rd_idx_reg <= '0;
            slot_reg   <= '0;
            hit_reg    <= 1'b0;
        end
        if (issue)
        begin
            rd_idx_reg   <= rd_idx_reg + CNT_W'(1);
            cmp_idx_reg  <= SLOT_W'(rd_idx_reg);
            cmp_vbit_reg <= valid_reg[SLOT_W'(rd_idx_reg)];
        end
        if (cmd.search_step && match)
        begin
            slot_reg <= cmp_idx_reg;
            hit_reg  <= 1'b1;
        end
        if (cmd.alloc)
        begin
            slot_reg <= fp_eff;
        end
    end

    // Result register.
    assign product = CODE_W'(base_reg) * (CODE_W + FACTOR_W)'(factor_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res.kind         <= kind_reg;
            res.slot         <= SLOTF_W'(slot_reg);
            res.hit          <= hit_reg;
            res.glyph_code   <= code_reg;
            res.font_offset  <= OFFSET_W'(product);
            res.control_char <= (kind_reg == KIND_CONTROL) ? lead_reg[CTRL_W-1:0] : '0;
            res.bytes_used   <= (kind_reg == KIND_DOUBLE) ? USED_TWO : USED_ONE;
            res.bad_trail    <= bad_reg;
        end
    end

    assign res.valid = res_valid_reg;

    assign st.is_glyph = !is_ctrl && !is_bad;
    assign st.hit      = cmd.search_step && match;
    assign st.miss     = cmp_valid_reg && !match && (CNT_W'(cmp_idx_reg) == n_last);
    assign st.out_free = !res_valid_reg || res.ready;

endmodule

// ----- sv/gbk_glyph_cache_slot_allocator_core.sv -----
// Top level of the GBK glyph cache slot allocator: sequencer, datapath and checks.
//
// Each transfer on chr carries one character as a lead byte and a trail byte.
// The block decodes it into a single-byte glyph, a double-byte GBK glyph or a
// control token. For a glyph it searches the slot table for the glyph code
// and either reports the slot that holds it or fills the slot at the FIFO
// fill pointer. Every character gives exactly one transfer on res with the
// slot, hit flag, glyph code and font memory byte offset.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the font size
// (index 0) and the number of slots in use (index 1); writing does not flush.
// Flow: a control token or bad trail byte goes from the decode state straight
// to the done state; a glyph searches until a hit or, on a miss, through all
// slots in use and then allocates the slot. The search reads one table
// entry per cycle from the slot code memory, and the block takes one
// character at a time, a new one only once the last result has been loaded.
// Reset clears all valid bits and the fill pointer, so the table starts empty
// and the block is ready at once. The result sits in an output register, so a
// stalled receiver holds the search of the next character only at its end.
module gbk_glyph_cache_slot_allocator_core import gbk_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    gbk_char_if.sink             chr,
    gbk_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    gbk_cmd_t  cmd;
    gbk_stat_t st;

    gbk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chr.valid),
        .in_ready (chr.ready),
        .st       (st),
        .cmd      (cmd)
    );

    gbk_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .lead_byte  (chr.lead_byte),
        .trail_byte (chr.trail_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res        (res)
    );

    a_alloc_glyph_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> st.is_glyph)
        else $error("Slot allocated for a control token or bad trail byte.");

    a_hit_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        st.hit |-> cmd.search_step && !cmd.alloc)
        else $error("Hit reported outside the search.");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (chr.valid && chr.ready) |=> !cmd.out_load && !chr.ready)
        else $error("Result loaded or new character taken right after a transfer.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("Result register overwritten while still held.");

endmodule
